// File: sv/srm_pkg.sv
package srm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = 6;
  localparam int IP_W        = 32;
  localparam int LEN_W       = IP_W + 1;
  localparam int CQ_DEPTH    = 2;
  localparam int CQ_PTR_W    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // lo carries the range start or the query address, hi the range end
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [IP_W-1:0]  lo;
    logic [IP_W-1:0]  hi;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: sv/srm_ram.sv
module srm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/srm_front.sv
module srm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind,
  input  logic [srm_pkg::IDX_W-1:0]     entry_index,
  input  logic [srm_pkg::IP_W-1:0]      range_start,
  input  logic [srm_pkg::IP_W-1:0]      range_end,
  input  logic [srm_pkg::IP_W-1:0]      query_address,
  output logic                          cmd_valid,
  output srm_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);

  srm_pkg::cmd_t                 slots [srm_pkg::CQ_DEPTH];
  logic [srm_pkg::CQ_PTR_W-1:0]  wr_ptr;
  logic [srm_pkg::CQ_PTR_W-1:0]  rd_ptr;
  logic [srm_pkg::CQ_CNT_W-1:0]  count;
  srm_pkg::cmd_t                 in_cmd;
  logic                          in_range;
  logic                          enq;
  logic                          deq;

  assign full      = (count == srm_pkg::CQ_CNT_W'(srm_pkg::CQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];

  assign in_range = (32'(entry_index) < 32'(srm_pkg::TABLE_DEPTH));

  always_comb begin
    in_cmd.op  = srm_pkg::op_t'(kind);
    in_cmd.idx = entry_index;
    in_cmd.lo  = (in_cmd.op == srm_pkg::OP_QUERY) ? query_address : range_start;
    in_cmd.hi  = range_end;
  end

  // writes to slots beyond the table are dropped here
  assign enq = push && !full && ((in_cmd.op == srm_pkg::OP_QUERY) || in_range);
  assign deq = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == srm_pkg::CQ_PTR_W'(srm_pkg::CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == srm_pkg::CQ_PTR_W'(srm_pkg::CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/srm_back.sv
module srm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  srm_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic                          found,
  output logic [srm_pkg::IDX_W-1:0]     match_index
);

  srm_pkg::state_t               state;
  srm_pkg::state_t               state_next;

  logic [srm_pkg::TABLE_DEPTH-1:0] marks;
  logic [srm_pkg::CNT_W-1:0]     iss_cnt;
  logic                          issuing;
  logic [srm_pkg::ADDR_W-1:0]    raddr;
  logic                          ram_we;
  logic [2*srm_pkg::IP_W-1:0]    rdata;
  logic [srm_pkg::IP_W-1:0]      qaddr;

  logic                          p1_valid;
  logic                          p1_mark;
  logic [srm_pkg::ADDR_W-1:0]    p1_idx;
  logic [srm_pkg::IP_W-1:0]      p1_start;
  logic [srm_pkg::IP_W-1:0]      p1_end;
  logic                          p1_hit;
  logic [srm_pkg::LEN_W-1:0]     p1_len;

  logic                          p2_valid;
  logic                          p2_hit;
  logic [srm_pkg::LEN_W-1:0]     p2_len;
  logic [srm_pkg::IP_W-1:0]      p2_start;
  logic [srm_pkg::ADDR_W-1:0]    p2_idx;
  logic                          p2_last;
  logic                          p2_better;

  logic                          have;
  logic [srm_pkg::LEN_W-1:0]     best_len;
  logic [srm_pkg::IP_W-1:0]      best_start;
  logic [srm_pkg::ADDR_W-1:0]    best_idx;

  logic                          out_valid;
  logic                          load_out;
  logic                          start_scan;

  srm_ram #(
    .WIDTH (2 * srm_pkg::IP_W),
    .DEPTH (srm_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (srm_pkg::ADDR_W'(cmd.idx)),
    .wdata ({cmd.hi, cmd.lo}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      srm_pkg::ST_IDLE: begin
        if (cmd_valid && (cmd.op == srm_pkg::OP_QUERY)) begin
          state_next = srm_pkg::ST_SCAN;
        end
      end
      srm_pkg::ST_SCAN: begin
        if (p2_valid && p2_last) begin
          state_next = srm_pkg::ST_DONE;
        end
      end
      srm_pkg::ST_DONE: begin
        if (!out_valid || pop) begin
          state_next = srm_pkg::ST_IDLE;
        end
      end
      default: state_next = srm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    start_scan = 1'b0;
    issuing    = 1'b0;
    load_out   = 1'b0;
    case (state)
      srm_pkg::ST_IDLE: begin
        cmd_pop    = cmd_valid;
        ram_we     = cmd_valid && (cmd.op == srm_pkg::OP_WRITE);
        start_scan = cmd_valid && (cmd.op == srm_pkg::OP_QUERY);
      end
      srm_pkg::ST_SCAN: begin
        issuing = (iss_cnt < srm_pkg::CNT_W'(srm_pkg::TABLE_DEPTH));
      end
      srm_pkg::ST_DONE: begin
        load_out = !out_valid || pop;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign raddr = iss_cnt[srm_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
    end else if (ram_we) begin
      marks[srm_pkg::ADDR_W'(cmd.idx)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      qaddr   <= cmd.lo;
      iss_cnt <= '0;
    end else if (issuing) begin
      iss_cnt <= iss_cnt + 1'b1;
    end
  end

  // stage 1: table data back from the ram
  assign p1_start = rdata[srm_pkg::IP_W-1:0];
  assign p1_end   = rdata[2*srm_pkg::IP_W-1:srm_pkg::IP_W];
  assign p1_hit   = p1_mark && (p1_start <= qaddr) && (qaddr <= p1_end);
  assign p1_len   = {1'b0, p1_end} - {1'b0, p1_start} + srm_pkg::LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= issuing;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx   <= raddr;
    p1_mark  <= marks[raddr];
    p2_hit   <= p1_valid && p1_hit;
    p2_len   <= p1_len;
    p2_start <= p1_start;
    p2_idx   <= p1_idx;
  end

  // stage 2: keep the shortest range, then smaller start, then later slot
  assign p2_last   = (p2_idx == srm_pkg::ADDR_W'(srm_pkg::TABLE_DEPTH - 1));
  assign p2_better = p2_hit && (!have || (p2_len < best_len) ||
                     ((p2_len == best_len) && (p2_start <= best_start)));

  always_ff @(posedge clk) begin
    if (start_scan) begin
      have <= 1'b0;
    end else if (p2_valid && p2_better) begin
      have       <= 1'b1;
      best_len   <= p2_len;
      best_start <= p2_start;
      best_idx   <= p2_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found       <= have;
      match_index <= have ? srm_pkg::IDX_W'(best_idx) : '0;
    end
  end

  assign empty = !out_valid;

endmodule

// File: sv/smallest_ip_range_match.sv
// Most-specific IPv4 range lookup over a table of srm_pkg::TABLE_DEPTH ranges,
// with queue-style ports on both sides (push/full in, empty/pop out). A write beat
// stores a range at a slot and marks it valid; writes to slots beyond the table are
// dropped. A query beat returns one result: found, and the slot of the shortest
// containing range (smaller start wins a tie, then the higher slot). Writes give no
// result. A query scans the range table through its single read port, one slot per
// cycle. A two-deep command queue lets new beats be taken while a scan runs, and a
// finished result waits in an output register. Valid marks clear at reset.
module smallest_ip_range_match (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind,
  input  logic [srm_pkg::IDX_W-1:0]     entry_index,
  input  logic [srm_pkg::IP_W-1:0]      range_start,
  input  logic [srm_pkg::IP_W-1:0]      range_end,
  input  logic [srm_pkg::IP_W-1:0]      query_address,
  output logic                          empty,
  input  logic                          pop,
  output logic                          found,
  output logic [srm_pkg::IDX_W-1:0]     match_index
);

  logic          cmd_valid;
  srm_pkg::cmd_t cmd;
  logic          cmd_pop;

  srm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .entry_index   (entry_index),
    .range_start   (range_start),
    .range_end     (range_end),
    .query_address (query_address),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  srm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .found       (found),
    .match_index (match_index)
  );

endmodule
